@@ design/bpe_pkg.sv @@
// Shared widths, types and register codes of the Bezier point evaluator.
`timescale 1ns / 1ps

package bpe_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int T_FRAC_BITS = 16;
    localparam int T_WIDTH     = T_FRAC_BITS + 1;

    // Intermediate points need one extra bit for an offset added to a coordinate.
    localparam int WIDE_WIDTH = COORD_WIDTH + 1;
    localparam int DIFF_WIDTH = WIDE_WIDTH + 1;
    localparam int PROD_WIDTH = DIFF_WIDTH + T_WIDTH + 1;

    localparam int NUM_AXES   = 2;
    localparam int NUM_LEVELS = 3;
    localparam int NUM_PTS    = NUM_LEVELS + 1;
    localparam int NUM_LANES  = NUM_PTS - 1;

    localparam int IN_FIELDS_WIDTH  = 4 * COORD_WIDTH + T_WIDTH;
    localparam int IN_TDATA_WIDTH   = ((IN_FIELDS_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH  = ((NUM_AXES * COORD_WIDTH + 7) / 8) * 8;
    localparam int CFG_ADDR_WIDTH   = 3;
    localparam int KIND_WIDTH       = 2;

    typedef logic signed [COORD_WIDTH-1:0]  coord_t;
    typedef logic signed [WIDE_WIDTH-1:0]   wide_t;
    typedef logic signed [DIFF_WIDTH-1:0]   diff_t;
    typedef logic signed [PROD_WIDTH-1:0]   prod_t;
    typedef logic [T_WIDTH-1:0]             tpar_t;
    typedef logic [NUM_LEVELS-1:0][T_WIDTH-1:0] tvec_t;

    localparam tpar_t  T_ONE     = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // Rounding constants: half up for a positive step, just under half for a negative one.
    localparam prod_t RND_POS = prod_t'(1) <<< (T_FRAC_BITS - 1);
    localparam prod_t RND_NEG = RND_POS - prod_t'(1);

    localparam logic [KIND_WIDTH-1:0] KIND_LINEAR = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_QUAD   = 2'd1;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_CURVE_KIND      = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_FIRST_OFFSET_X  = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_FIRST_OFFSET_Y  = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SECOND_OFFSET_X = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SECOND_OFFSET_Y = 3'd4;

endpackage

@@ design/bezier_point_evaluator_top.sv @@
// Pipelined de Casteljau evaluator of linear, quadratic and cubic Bezier points.
`timescale 1ns / 1ps
//
//  channel  | direction | ports                       | payload
//  ---------+-----------+-----------------------------+-------------------------------------
//  s_axis   | in        | tvalid, tready, tdata[151:0]| start_x, start_y, end_x, end_y, t
//  m_axis   | out       | tvalid, tready, tdata[63:0] | point_x, point_y
//  cfg      | in        | valid, ready, addr, data    | register index, write data
//
//  One transaction per cycle in and out while the skid entry is empty and the sink is ready.
//  Each lerp level is a three-stage lane (difference, 34x18 multiply, round and add), three
//  levels deep, after three stages that build the control points.
//  Reset clears the configuration registers and empties the pipeline; cfg_ready is always high.
//  The output register has a one-entry skid behind it; the pipeline and s_axis_tready hold
//  only while the skid entry is occupied.

module bezier_point_evaluator_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // start_x, start_y, end_x, end_y, t_param, zero pad
    input  logic [bpe_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // point_x, point_y
    output logic [bpe_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bpe_pkg::CFG_ADDR_WIDTH-1:0]    cfg_addr,
    input  logic [bpe_pkg::COORD_WIDTH-1:0]       cfg_data
);

    localparam int CW         = bpe_pkg::COORD_WIDTH;
    localparam int F          = bpe_pkg::T_FRAC_BITS;
    localparam int WW         = bpe_pkg::WIDE_WIDTH;
    localparam int DW         = bpe_pkg::DIFF_WIDTH;
    localparam int AX         = bpe_pkg::NUM_AXES;
    localparam int NL         = bpe_pkg::NUM_LEVELS;
    localparam int NP         = bpe_pkg::NUM_PTS;
    localparam int LN         = bpe_pkg::NUM_LANES;
    localparam int ST_IN      = 0;
    localparam int ST_CTRL    = 2;
    localparam int NUM_STAGES = 3 + 3 * NL;

    // Configuration registers
    logic [bpe_pkg::KIND_WIDTH-1:0] curve_kind_reg;
    bpe_pkg::coord_t                first_off_reg  [AX];
    bpe_pkg::coord_t                second_off_reg [AX];

    // Pipeline control
    logic [NUM_STAGES-1:0] vld_reg;
    logic                  en;
    logic                  push;
    logic                  take;

    // Input stage
    bpe_pkg::wide_t in_a_next [AX];
    bpe_pkg::wide_t in_b_next [AX];
    bpe_pkg::wide_t in_d_next [AX];
    bpe_pkg::tpar_t in_t_next;
    bpe_pkg::wide_t in_a_reg  [AX];
    bpe_pkg::wide_t in_b_reg  [AX];
    bpe_pkg::wide_t in_d_reg  [AX];
    bpe_pkg::tpar_t in_t_reg;

    // Midpoint stage
    bpe_pkg::wide_t md_mid_next [AX];
    bpe_pkg::wide_t md_a_reg    [AX];
    bpe_pkg::wide_t md_b_reg    [AX];
    bpe_pkg::wide_t md_mid_reg  [AX];
    bpe_pkg::tpar_t md_t_reg;

    // Control point stage
    bpe_pkg::wide_t ct_pt_next [NP][AX];
    bpe_pkg::tvec_t ct_t_next;
    bpe_pkg::wide_t ct_pt_reg  [NP][AX];
    bpe_pkg::tvec_t ct_t_reg;

    // Lerp levels
    bpe_pkg::wide_t lv_in       [NL][NP][AX];
    bpe_pkg::wide_t lv_p_a_next [NL][LN][AX];
    bpe_pkg::diff_t lv_diff_next[NL][LN][AX];
    bpe_pkg::tvec_t lv_t_a_next [NL];
    bpe_pkg::wide_t lv_p_a_reg  [NL][LN][AX];
    bpe_pkg::diff_t lv_diff_reg [NL][LN][AX];
    bpe_pkg::tvec_t lv_t_a_reg  [NL];
    bpe_pkg::prod_t lv_prod_next[NL][LN][AX];
    bpe_pkg::wide_t lv_p_b_reg  [NL][LN][AX];
    logic           lv_neg_reg  [NL][LN][AX];
    bpe_pkg::prod_t lv_prod_reg [NL][LN][AX];
    bpe_pkg::tvec_t lv_t_b_reg  [NL];
    bpe_pkg::wide_t lv_res_next [NL][LN][AX];
    bpe_pkg::wide_t lv_res_reg  [NL][LN][AX];
    bpe_pkg::tvec_t lv_t_c_reg  [NL];

    // Output register and skid entry
    bpe_pkg::coord_t sat_next  [AX];
    bpe_pkg::coord_t out_reg   [AX];
    bpe_pkg::coord_t skid_reg  [AX];
    logic            out_vld_reg;
    logic            skid_vld_reg;

    function automatic bpe_pkg::coord_t sat_coord(input bpe_pkg::wide_t v);
        bpe_pkg::coord_t r;
        if (v[WW-1] != v[WW-2])
        begin
            r = v[WW-1] ? bpe_pkg::COORD_MIN : bpe_pkg::COORD_MAX;
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------ configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_kind_reg <= bpe_pkg::KIND_LINEAR;
            for (int a = 0; a < AX; a++)
            begin
                first_off_reg[a]  <= '0;
                second_off_reg[a] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                bpe_pkg::REG_CURVE_KIND:      curve_kind_reg    <= cfg_data[1:0];
                bpe_pkg::REG_FIRST_OFFSET_X:  first_off_reg[0]  <= cfg_data;
                bpe_pkg::REG_FIRST_OFFSET_Y:  first_off_reg[1]  <= cfg_data;
                bpe_pkg::REG_SECOND_OFFSET_X: second_off_reg[0] <= cfg_data;
                bpe_pkg::REG_SECOND_OFFSET_Y: second_off_reg[1] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------ flow control
    // Advance the whole pipeline unless the skid entry is occupied.
    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;
    assign push          = en && vld_reg[NUM_STAGES-1];
    assign take          = out_vld_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_axis_tvalid};
        end
    end

    // ------------------------------------------------------------------ input stage
    always_comb
    begin
        for (int a = 0; a < AX; a++)
        begin
            in_a_next[a] = {s_axis_tdata[a*CW+CW-1], s_axis_tdata[a*CW +: CW]};
            in_b_next[a] = {s_axis_tdata[(2+a)*CW+CW-1], s_axis_tdata[(2+a)*CW +: CW]};
            in_d_next[a] = in_b_next[a] - in_a_next[a];
        end
        // Clamp t above one to one
        in_t_next = s_axis_tdata[4*CW +: bpe_pkg::T_WIDTH];
        if (in_t_next > bpe_pkg::T_ONE)
        begin
            in_t_next = bpe_pkg::T_ONE;
        end
    end

    // ------------------------------------------------------------------ midpoint stage
    always_comb
    begin
        bpe_pkg::diff_t dd;
        bpe_pkg::diff_t hf;
        for (int a = 0; a < AX; a++)
        begin
            // Half the span, rounded to nearest with ties away from zero
            dd = {in_d_reg[a][WW-1], in_d_reg[a]} + bpe_pkg::diff_t'(!in_d_reg[a][WW-1]);
            hf = dd >>> 1;
            md_mid_next[a] = in_a_reg[a] + bpe_pkg::wide_t'(hf[WW-1:0]);
        end
    end

    // ------------------------------------------------------------------ control points
    always_comb
    begin
        for (int a = 0; a < AX; a++)
        begin
            ct_pt_next[0][a]    = md_a_reg[a];
            ct_pt_next[NP-1][a] = md_b_reg[a];
            unique case (curve_kind_reg)
                bpe_pkg::KIND_LINEAR:
                begin
                    ct_pt_next[1][a] = md_b_reg[a];
                    ct_pt_next[2][a] = md_b_reg[a];
                end
                bpe_pkg::KIND_QUAD:
                begin
                    ct_pt_next[1][a] = md_mid_reg[a]
                                     + {first_off_reg[a][CW-1], first_off_reg[a]};
                    ct_pt_next[2][a] = md_b_reg[a];
                end
                default:
                begin
                    ct_pt_next[1][a] = md_a_reg[a]
                                     + {first_off_reg[a][CW-1], first_off_reg[a]};
                    ct_pt_next[2][a] = md_b_reg[a]
                                     + {second_off_reg[a][CW-1], second_off_reg[a]};
                end
            endcase
        end
        // A level with t of zero passes its points through unchanged.
        unique case (curve_kind_reg)
            bpe_pkg::KIND_LINEAR: ct_t_next = {md_t_reg, bpe_pkg::tpar_t'(0), bpe_pkg::tpar_t'(0)};
            bpe_pkg::KIND_QUAD:   ct_t_next = {md_t_reg, md_t_reg, bpe_pkg::tpar_t'(0)};
            default:              ct_t_next = {md_t_reg, md_t_reg, md_t_reg};
        endcase
    end

    // ------------------------------------------------------------------ lerp levels
    always_comb
    begin
        for (int p = 0; p < NP; p++)
        begin
            for (int a = 0; a < AX; a++)
            begin
                lv_in[0][p][a] = ct_pt_reg[p][a];
            end
        end
        for (int l = 1; l < NL; l++)
        begin
            for (int p = 0; p < NP; p++)
            begin
                for (int a = 0; a < AX; a++)
                begin
                    lv_in[l][p][a] = (p == NP - 1) ? lv_res_reg[l-1][LN-1][a]
                                                   : lv_res_reg[l-1][p][a];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            lv_t_a_next[l] = (l == 0) ? ct_t_reg : lv_t_c_reg[(l == 0) ? 0 : l - 1];
            for (int n = 0; n < LN; n++)
            begin
                for (int a = 0; a < AX; a++)
                begin
                    // Level l has one lane fewer than the level before it
                    if (n < LN - l)
                    begin
                        lv_p_a_next[l][n][a]  = lv_in[l][n][a];
                        lv_diff_next[l][n][a] = {lv_in[l][n+1][a][WW-1], lv_in[l][n+1][a]}
                                              - {lv_in[l][n][a][WW-1], lv_in[l][n][a]};
                    end
                    else
                    begin
                        lv_p_a_next[l][n][a]  = '0;
                        lv_diff_next[l][n][a] = '0;
                    end
                    lv_prod_next[l][n][a] = lv_diff_reg[l][n][a]
                                          * $signed({1'b0, lv_t_a_reg[l][l]});
                    // p + round(prod / 2^F), the round folded into one three-input add
                    lv_res_next[l][n][a] = bpe_pkg::wide_t'(
                        ((bpe_pkg::prod_t'(lv_p_b_reg[l][n][a]) <<< F)
                         + lv_prod_reg[l][n][a]
                         + (lv_neg_reg[l][n][a] ? bpe_pkg::RND_NEG : bpe_pkg::RND_POS))
                        >>> F);
                end
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < AX; a++)
        begin
            sat_next[a] = sat_coord(lv_res_reg[NL-1][0][a]);
        end
    end

    // ------------------------------------------------------------------ payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_a_reg   <= in_a_next;
            in_b_reg   <= in_b_next;
            in_d_reg   <= in_d_next;
            in_t_reg   <= in_t_next;
            md_a_reg   <= in_a_reg;
            md_b_reg   <= in_b_reg;
            md_mid_reg <= md_mid_next;
            md_t_reg   <= in_t_reg;
            ct_pt_reg  <= ct_pt_next;
            ct_t_reg   <= ct_t_next;
            lv_p_a_reg  <= lv_p_a_next;
            lv_diff_reg <= lv_diff_next;
            lv_t_a_reg  <= lv_t_a_next;
            lv_p_b_reg  <= lv_p_a_reg;
            lv_prod_reg <= lv_prod_next;
            lv_t_b_reg  <= lv_t_a_reg;
            lv_res_reg  <= lv_res_next;
            lv_t_c_reg  <= lv_t_b_reg;
            for (int l = 0; l < NL; l++)
            begin
                for (int n = 0; n < LN; n++)
                begin
                    for (int a = 0; a < AX; a++)
                    begin
                        lv_neg_reg[l][n][a] <= lv_diff_reg[l][n][a][DW-1];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------ output and skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            priority if (take && skid_vld_reg)
            begin
                skid_vld_reg <= 1'b0;
            end
            else if (take)
            begin
                out_vld_reg <= push;
            end
            else if (push && out_vld_reg)
            begin
                skid_vld_reg <= 1'b1;
            end
            else if (push)
            begin
                out_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (take && skid_vld_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (push && (take || !out_vld_reg))
        begin
            out_reg <= sat_next;
        end
        else if (push)
        begin
            skid_reg <= sat_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = bpe_pkg::OUT_TDATA_WIDTH'({out_reg[1], out_reg[0]});

    // ------------------------------------------------------------------ assertions
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[ST_IN])
        else $error("accepted transaction did not enter the input stage");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry holds data while the output register is empty");

    a_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_IN] |-> in_t_reg <= bpe_pkg::T_ONE)
        else $error("t above one reached the pipeline");

    a_linear_pass: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_CTRL] && curve_kind_reg == bpe_pkg::KIND_LINEAR
        |-> ct_t_reg[0] == '0 && ct_t_reg[1] == '0)
        else $error("linear curve does not bypass the first two levels");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        push && out_vld_reg && !m_axis_tready |=> skid_vld_reg)
        else $error("result pushed into a full output register was lost");

endmodule
